// File: sv/rsk_pkg.sv
// Shared types and constants for the record sort block.
`timescale 1ns / 1ps

package rsk_pkg;

    localparam int ID_W  = 32;
    localparam int KEY_W = 32;

    // One stored record; the key sits in the upper half.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CARRY,
        OP_CMP,
        OP_TAIL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic overflow;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// File: sv/rsk_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rsk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rsk_datapath.sv
// Record store, bubbling carry register, compare-and-swap and output register.
`timescale 1ns / 1ps

module rsk_datapath #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rsk_pkg::ID_W-1:0]         in_id,
    input  logic [rsk_pkg::KEY_W-1:0]        in_key,
    input  rsk_pkg::cmd_t                    cmd,
    input  logic [$clog2(MAX_RECORDS)-1:0]   wr_addr,
    input  logic [$clog2(MAX_RECORDS)-1:0]   rd_addr,
    output rsk_pkg::stat_t                   stat,
    output logic [rsk_pkg::ID_W-1:0]         out_id,
    output logic [rsk_pkg::KEY_W-1:0]        out_key,
    output logic                             out_last,
    output logic                             overflow,
    output logic                             out_valid,
    input  logic                             out_ready
);

    import rsk_pkg::*;

    rec_t rd_rec;
    rec_t wr_rec;
    logic wr_en;
    logic swap;

    rec_t carry_reg;
    rec_t carry_next;
    rec_t out_rec_reg;
    logic out_last_reg;
    logic out_ovf_reg;
    logic out_valid_reg;
    logic out_valid_next;

    rsk_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

    // Only a strictly greater key moves the carried record past its neighbor.
    assign swap = carry_reg.key > rd_rec.key;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_rec     = carry_reg;
        carry_next = carry_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                wr_en  = 1'b1;
                wr_rec = '{key: in_key, id: in_id};
            end
            OP_CARRY:
            begin
                carry_next = rd_rec;
            end
            OP_CMP:
            begin
                wr_en = 1'b1;
                if (swap)
                begin
                    wr_rec = rd_rec;
                end
                else
                begin
                    wr_rec     = carry_reg;
                    carry_next = rd_rec;
                end
            end
            OP_TAIL:
            begin
                wr_en  = 1'b1;
                wr_rec = carry_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.op == OP_EMIT)
        begin
            out_rec_reg  <= rd_rec;
            out_last_reg <= cmd.last;
            out_ovf_reg  <= cmd.overflow;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_id        = out_rec_reg.id;
    assign out_key       = out_rec_reg.key;
    assign out_last      = out_last_reg;
    assign overflow      = out_ovf_reg;

endmodule

// File: sv/rsk_ctrl.sv
// Controller: load, bubble-sort passes and emission sequencing.
`timescale 1ns / 1ps

module rsk_ctrl #(
    parameter int MAX_RECORDS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_last,
    output logic                           in_ready,
    output rsk_pkg::cmd_t                  cmd,
    input  rsk_pkg::stat_t                 stat,
    output logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
    output logic [$clog2(MAX_RECORDS)-1:0] rd_addr
);

    import rsk_pkg::*;

    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0]  CAP = CNT_W'(MAX_RECORDS);
    localparam logic [ADDR_W-1:0] TOP = ADDR_W'(MAX_RECORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_CARRY,
        S_CMP,
        S_TAIL,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t            state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic              dropped_reg,  dropped_next;
    logic [ADDR_W-1:0] limit_reg,    limit_next;
    logic [ADDR_W-1:0] idx_reg,      idx_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0] emit_reg,     emit_next;
    logic              full;
    logic [ADDR_W-1:0] last_pos;

    assign full     = (count_reg == CAP);
    assign last_pos = full ? TOP : count_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        limit_next    = limit_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        emit_next     = emit_reg;
        cmd           = '{op: OP_NONE, last: 1'b0, overflow: 1'b0};
        wr_addr       = idx_reg;
        rd_addr       = '0;
        in_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD;
                        wr_addr    = count_reg[ADDR_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        last_idx_next = last_pos;
                        limit_next    = last_pos;
                        emit_next     = '0;
                        // A single record needs no pass.
                        state_next    = (last_pos == '0) ? S_EMIT_RD : S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                rd_addr    = '0;
                state_next = S_CARRY;
            end
            S_CARRY:
            begin
                cmd.op     = OP_CARRY;
                rd_addr    = ADDR_W'(1);
                idx_next   = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op   = OP_CMP;
                wr_addr  = idx_reg;
                rd_addr  = idx_reg + ADDR_W'(2);
                idx_next = idx_reg + 1'b1;
                if ((idx_reg + 1'b1) == limit_reg)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // The carried record is the largest of this pass and settles at the limit.
                cmd.op     = OP_TAIL;
                wr_addr    = limit_reg;
                rd_addr    = '0;
                limit_next = limit_reg - 1'b1;
                if (limit_reg == ADDR_W'(1))
                begin
                    emit_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_CARRY;
                end
            end
            S_EMIT_RD:
            begin
                rd_addr = emit_reg;
                if (stat.out_free)
                begin
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                cmd.op       = OP_EMIT;
                cmd.last     = (emit_reg == last_idx_reg);
                cmd.overflow = dropped_reg;
                if (emit_reg == last_idx_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            limit_reg    <= '0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
            emit_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            limit_reg    <= limit_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
            emit_reg     <= emit_next;
        end
    end

endmodule

// File: sv/record_sort_by_key.sv
// Top level of the record sort block: controller plus datapath.
`timescale 1ns / 1ps

// Collects a set of records on the s_axis channel and returns them on the
// m_axis channel sorted ascending by key; equal keys keep their load order.
// Each input transfer carries one record (id, key); s_axis_tlast closes the set.
// Up to MAX_RECORDS records are kept; further records of the set are dropped
// and every output record of that set then shows m_axis_tuser high.
// Loading takes one record per cycle. After the closing transfer the block
// stops accepting input and sorts the kept records in the store memory, one
// compare-and-swap per cycle; a single record needs no sort. The single write
// and single read port of the store set this pace. It then emits the records
// in order, each read from the store and then loaded into the output
// register, m_axis_tlast on the final one, and takes new input as soon as
// the final record is in the output register. A stalled receiver holds the
// output register and pauses emission without losing a record. Reset empties
// the set and clears the output valid; the store needs no clearing, since
// only written entries are used.
module record_sort_by_key #(
    parameter int MAX_RECORDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // record_id [31:0], salary_key [63:32]
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_id [31:0], out_key [63:32]
    output logic        m_axis_tlast,   // out_last
    output logic        m_axis_tuser    // overflow
);

    import rsk_pkg::*;

    localparam int ADDR_W = $clog2(MAX_RECORDS);

    cmd_t              cmd;
    stat_t             stat;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ID_W-1:0]   out_id;
    logic [KEY_W-1:0]  out_key;

    rsk_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    rsk_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_id     (s_axis_tdata[ID_W-1:0]),
        .in_key    (s_axis_tdata[ID_W+KEY_W-1:ID_W]),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .stat      (stat),
        .out_id    (out_id),
        .out_key   (out_key),
        .out_last  (m_axis_tlast),
        .overflow  (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_key, out_id};

endmodule

// File: sv/rsk_checker.sv
// Port-level checks of the record sort block, bound to the top level.
`timescale 1ns / 1ps

module rsk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    logic        in_set_reg;
    logic [31:0] prev_key_reg;
    logic        prev_ovf_reg;
    logic        out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Tracks the previous output transfer of the set still being emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_set_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            in_set_reg <= !m_axis_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_xfer)
        begin
            prev_key_reg <= m_axis_tdata[63:32];
            prev_ovf_reg <= m_axis_tuser;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output record changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after the closing record");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && in_set_reg |-> m_axis_tdata[63:32] >= prev_key_reg)
        else $error("output keys out of ascending order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && in_set_reg |-> m_axis_tuser == prev_ovf_reg)
        else $error("overflow flag changed within a set");

    // The first edge after reset is released must find the output empty.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind record_sort_by_key rsk_checker u_rsk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_record_sort_by_key.sv
// Self-checking testbench for record_sort_by_key: directed sets, random sets, stalls on both sides.
`timescale 1ns / 1ps

module tb_record_sort_by_key;
    import rsk_pkg::*;

    localparam int MAX_RECORDS  = 16;
    localparam int RANDOM_ITEMS = 145;
    localparam int CALM_AFTER   = 115;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             last;
        logic             overflow;
    } sorted_rec_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             last;
        logic             known;
        sorted_rec_t      res;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // Predictor state: records held for the open set.
    rec_t        held [MAX_RECORDS];
    int          held_count   = 0;
    bit          held_dropped = 1'b0;
    sorted_rec_t sorted_q [$];
    stim_row_t   directed [$];

    bit calm          = 1'b0;
    int stall_left    = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int sets_done     = 0;
    int overflow_sets = 0;
    int results_seen  = 0;

    record_sort_by_key #(
        .MAX_RECORDS(MAX_RECORDS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d sorted records still pending", sorted_q.size());
        $display("tb_record_sort_by_key: errors");
        $finish;
    end

    // Stores one record and, when it closes the set, sorts the held records and
    // queues them as the expected output.
    function automatic void take_record(input logic [ID_W-1:0] id, input logic [KEY_W-1:0] key,
                                        input logic last, input bit queue_results);
        rec_t        swap_rec;
        sorted_rec_t r;
        if (held_count < MAX_RECORDS)
        begin
            held[held_count].id  = id;
            held[held_count].key = key;
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (!last)
            return;
        // Only a strictly greater key swaps, which keeps equal keys in load order.
        for (int pass = 1; pass < held_count; pass++)
        begin
            for (int i = 0; i + pass < held_count; i++)
            begin
                if (held[i].key > held[i + 1].key)
                begin
                    swap_rec    = held[i];
                    held[i]     = held[i + 1];
                    held[i + 1] = swap_rec;
                end
            end
        end
        if (queue_results)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                r.id       = held[k].id;
                r.key      = held[k].key;
                r.last     = (k == held_count - 1);
                r.overflow = held_dropped;
                sorted_q.push_back(r);
            end
        end
        sets_done++;
        if (held_dropped)
            overflow_sets++;
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    function automatic void add_row(input logic [ID_W-1:0] id, input logic [KEY_W-1:0] key,
                                    input logic last, input logic known, input sorted_rec_t res);
        stim_row_t row;
        row.id    = id;
        row.key   = key;
        row.last  = last;
        row.known = known;
        row.res   = res;
        directed.push_back(row);
    endfunction

    task automatic send_record(input logic [ID_W-1:0] id, input logic [KEY_W-1:0] key,
                               input logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key, id};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Receiver: stalls come in bursts of random length.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 11);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sorted_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (sorted_q.size() == 0)
            begin
                $error("unexpected output transfer: id %h key %h", m_axis_tdata[31:0],
                       m_axis_tdata[63:32]);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (m_axis_tdata[31:0] !== want.id)
                begin
                    $error("out_id: expected %h, got %h", want.id, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== want.key)
                begin
                    $error("out_key: expected %h, got %h", want.key, m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("out_last: expected %b, got %b", want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.overflow)
                begin
                    $error("overflow: expected %b, got %b", want.overflow, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t        row;
        int               set_len;
        int               key_mode;
        int               rand_sent;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             closes;

        // Single-record sets at both extremes come back unchanged.
        add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, {32'h0000_0000, 32'h0000_0000, 2'b10});
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b10});
        // Three equal keys must keep their load order.
        add_row(32'h0000_00A1, 32'd12345, 1'b0, 1'b0, '0);
        add_row(32'h0000_00A2, 32'd12345, 1'b0, 1'b0, '0);
        add_row(32'h0000_00A3, 32'd12345, 1'b1, 1'b0, '0);
        // A full set, then one dropped record and a dropped closing record.
        add_row(32'h0000_1000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'h0000_1001, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(32'h0000_1002, 32'd100,       1'b0, 1'b0, '0);
        add_row(32'h0000_1003, 32'd100,       1'b0, 1'b0, '0);
        add_row(32'h0000_1004, 32'h8000_0000, 1'b0, 1'b0, '0);
        add_row(32'h0000_1005, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'h0000_1006, 32'd1,         1'b0, 1'b0, '0);
        add_row(32'h0000_1007, 32'd250000,    1'b0, 1'b0, '0);
        add_row(32'h0000_1008, 32'd100,       1'b0, 1'b0, '0);
        add_row(32'h0000_1009, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(32'h0000_100A, 32'hFFFF_FFFE, 1'b0, 1'b0, '0);
        add_row(32'h0000_100B, 32'd99,        1'b0, 1'b0, '0);
        add_row(32'h0000_100C, 32'd101,       1'b0, 1'b0, '0);
        add_row(32'h0000_100D, 32'd42,        1'b0, 1'b0, '0);
        add_row(32'h0000_100E, 32'd42,        1'b0, 1'b0, '0);
        add_row(32'h0000_100F, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'h5555_AAAA, 32'h0000_0003, 1'b0, 1'b0, '0);
        add_row(32'hAAAA_5555, 32'h0000_0002, 1'b1, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            send_record(row.id, row.key, row.last);
            take_record(row.id, row.key, row.last, !row.known);
            if (row.known)
                sorted_q.push_back(row.res);
        end

        // Random sets: mostly within capacity, some past it, keys from wide,
        // narrow (many ties) and edge-heavy ranges.
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                set_len = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
            else
                set_len = $urandom_range(1, MAX_RECORDS);
            key_mode = $urandom_range(0, 2);
            for (int k = 0; k < set_len; k++)
            begin
                id = $urandom;
                case (key_mode)
                    0: key = $urandom;
                    1: key = $urandom_range(0, 7);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       key = '0;
                            1:       key = '1;
                            2:       key = 32'h8000_0000 | $urandom_range(0, 1);
                            default: key = $urandom;
                        endcase
                    end
                endcase
                closes = (k == set_len - 1);
                calm   = (rand_sent >= CALM_AFTER);
                send_record(id, key, closes);
                take_record(id, key, closes, 1'b1);
                rand_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d records sent in %0d sets (%0d with dropped records), %0d sorted records checked",
                 items_sent, sets_done, overflow_sets, results_seen);
        if (fail_count == 0)
            $display("tb_record_sort_by_key: clean");
        else
            $display("tb_record_sort_by_key: errors");
        $finish;
    end

endmodule
